FILE: rtl/stepper_half_step_ramp_controller_top_macros.svh
// ----------------------------------------------------------------------------
// stepper ramp controller assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef STEPPER_HALF_STEP_RAMP_CONTROLLER_TOP_MACROS_SVH
`define STEPPER_HALF_STEP_RAMP_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SHR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SHR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/shr_pkg.sv
// ----------------------------------------------------------------------------
// shr_pkg
// types, codes and constants of the stepper half-step ramp controller
// ----------------------------------------------------------------------------
`default_nettype none

package shr_pkg;

	localparam int DEF_TICKS_PER_MS = 1000;
	localparam logic [15:0] MIN_INTERVAL = 16'd200;
	localparam logic [15:0] MAX_INTERVAL = 16'd65535;
	localparam logic [31:0] ONE_MILLION = 32'd1000000;
	localparam logic [30:0] CNT_MAX = 31'h7FFF_FFFF;
	localparam logic [23:0] MS_MAX = 24'hFF_FFFF;

	// ops
	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_MOVE = 3'd1;
	localparam logic [2:0] OP_CONT = 3'd2;
	localparam logic [2:0] OP_SOFT = 3'd3;
	localparam logic [2:0] OP_ESTOP = 3'd4;

	// register indexes
	localparam logic [2:0] CFG_SPEED = 3'd0;
	localparam logic [2:0] CFG_MAX_SPEED = 3'd1;
	localparam logic [2:0] CFG_RAMP = 3'd2;
	localparam logic [2:0] CFG_DEF_CW = 3'd3;
	localparam logic [2:0] CFG_INVERT = 3'd4;
	localparam logic [2:0] CFG_TIMEOUT = 3'd5;

	// divider jobs
	localparam logic [1:0] DK_CRUISE = 2'd0;
	localparam logic [1:0] DK_FAST = 2'd1;
	localparam logic [1:0] DK_RAMP = 2'd2;

	typedef struct packed {
		logic [2:0] op;
		logic signed [31:0] step_count;
		logic cont_dir_cw;
	} in_t;

	typedef struct packed {
		logic [3:0] coil_pattern;
		logic stepped;
		logic running;
		logic [30:0] steps_done;
		logic [30:0] steps_goal;
		logic finished;
		logic success;
	} out_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_take;
		logic [1:0] div_kind;
		logic exec;
		logic mul;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic dirty;
		logic need_div;
		logic div_done;
		logic out_free;
	} sts_t;

	function automatic logic [3:0] half_step(input logic [2:0] pos);
		logic [3:0] pat;
		case (pos)
			3'd0: pat = 4'b0001;
			3'd1: pat = 4'b0011;
			3'd2: pat = 4'b0010;
			3'd3: pat = 4'b0110;
			3'd4: pat = 4'b0100;
			3'd5: pat = 4'b1100;
			3'd6: pat = 4'b1000;
			default: pat = 4'b1001;
		endcase
		return pat;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/shr_div.sv
// ----------------------------------------------------------------------------
// shr_div
// restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module shr_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);

	logic [15:0] rem_q;
	logic [15:0] dsr_q;
	logic [31:0] quo_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic        ge;
	logic [16:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign ge = trial >= {1'b0, dsr_q};
	assign diff = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 16'd0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/shr_dp.sv
// ----------------------------------------------------------------------------
// shr_dp
// datapath: registers, motion state, item execution, divider and output
// ----------------------------------------------------------------------------
`default_nettype none

module shr_dp #(
	parameter int TICKS_PER_MS = shr_pkg::DEF_TICKS_PER_MS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [23:0]   cfg_data,
	input  wire shr_pkg::in_t  in_data,
	input  wire logic          out_ready,
	input  wire shr_pkg::cmd_t cmd,
	output shr_pkg::sts_t      sts,
	output logic               out_valid,
	output shr_pkg::out_t      out_data
);

	localparam int SW = $clog2(TICKS_PER_MS + 1);
	localparam logic [SW-1:0] TPM = SW'(TICKS_PER_MS);

	// configuration
	logic [15:0] speed_q;
	logic [12:0] maxsp_q;
	logic [15:0] ramp_q;
	logic        defcw_q;
	logic        inv_q;
	logic [23:0] tmo_q;
	logic        dirty_q;

	// motion state
	logic        active_q, coils_q, fwd_q, rampon_q;
	logic [2:0]  phase_q;
	logic [30:0] goal_q, done_q;
	logic [15:0] now_q, cruise_q, fast_q, tick_q;
	logic [SW-1:0] subms_q;
	logic [23:0] ems_q;

	// item work
	shr_pkg::in_t item_q;
	logic        stepped_q, fin_q, succ_q, need_q;
	logic [15:0] mop_q;
	logic [31:0] prod_q;
	shr_pkg::out_t out_q;
	logic        out_valid_q;

	// next values from execution
	logic        nx_active, nx_coils, nx_fwd, nx_rampon;
	logic [2:0]  nx_phase;
	logic [30:0] nx_goal, nx_done;
	logic [15:0] nx_now, nx_tick;
	logic [SW-1:0] nx_sub;
	logic [23:0] nx_ems;
	logic        nx_stepped, nx_fin, nx_succ, nx_need;
	logic [15:0] nx_mop;

	logic [31:0] raw, mag;
	logic        tmo;
	logic [SW-1:0] sub1;
	logic [16:0] t1;
	logic [30:0] d1, rem;
	logic        c1, c2;
	logic [31:0] ng;

	// divider
	logic [31:0] div_a, quo;
	logic [15:0] div_b, q_clamp;
	logic        div_done;
	logic [15:0] span;

	assign span = cruise_q - fast_q;

	always_comb begin
		case (cmd.div_kind)
			shr_pkg::DK_CRUISE: begin
				div_a = shr_pkg::ONE_MILLION;
				div_b = speed_q;
			end
			shr_pkg::DK_FAST: begin
				div_a = shr_pkg::ONE_MILLION;
				div_b = {3'd0, maxsp_q};
			end
			default: begin
				div_a = prod_q;
				div_b = ramp_q;
			end
		endcase
	end

	// a zero divisor yields all ones, which clamps to the longest interval
	always_comb begin
		if (quo > {16'd0, shr_pkg::MAX_INTERVAL}) q_clamp = shr_pkg::MAX_INTERVAL;
		else if (quo[15:0] < shr_pkg::MIN_INTERVAL) q_clamp = shr_pkg::MIN_INTERVAL;
		else q_clamp = quo[15:0];
	end

	shr_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.dividend(div_a),
		.divisor(div_b),
		.done(div_done),
		.quotient(quo)
	);

	always_comb begin
		nx_active = active_q;
		nx_coils = coils_q;
		nx_fwd = fwd_q;
		nx_rampon = rampon_q;
		nx_phase = phase_q;
		nx_goal = goal_q;
		nx_done = done_q;
		nx_now = now_q;
		nx_tick = tick_q;
		nx_sub = subms_q;
		nx_ems = ems_q;
		nx_stepped = 1'b0;
		nx_fin = 1'b0;
		nx_succ = 1'b0;
		nx_need = 1'b0;
		nx_mop = mop_q;
		raw = item_q.step_count;
		mag = raw[31] ? (32'd0 - raw) : raw;
		if (mag[31]) mag = {1'b0, shr_pkg::CNT_MAX};
		tmo = 1'b0;
		sub1 = subms_q + SW'(1);
		t1 = {1'b0, tick_q} + 17'd1;
		d1 = (done_q == shr_pkg::CNT_MAX) ? done_q : done_q + 31'd1;
		rem = (goal_q > d1) ? goal_q - d1 : 31'd0;
		c1 = (ramp_q != 16'd0) && (d1 <= {15'd0, ramp_q}) && (rem > {15'd0, ramp_q});
		c2 = (ramp_q != 16'd0) && (rem <= {15'd0, ramp_q}) && (rem != 31'd0);
		ng = {1'b0, done_q} + ((rampon_q && ramp_q != 16'd0) ? {16'd0, ramp_q} : 32'd0);
		if (ng > {1'b0, goal_q}) ng = {1'b0, goal_q};

		case (item_q.op)
			shr_pkg::OP_TICK: begin
				if (active_q) begin
					if (goal_q != 31'd0) begin
						if (sub1 >= TPM) begin
							nx_sub = '0;
							if (ems_q != shr_pkg::MS_MAX) nx_ems = ems_q + 24'd1;
						end else begin
							nx_sub = sub1;
						end
						tmo = nx_ems > tmo_q;
					end
					if (tmo) begin
						nx_active = 1'b0;
						nx_coils = 1'b0;
						nx_goal = '0;
						nx_done = '0;
						nx_tick = '0;
						nx_fin = 1'b1;
					end else if (t1 >= {1'b0, now_q}) begin
						nx_tick = '0;
						nx_stepped = 1'b1;
						nx_phase = fwd_q ? phase_q + 3'd1 : phase_q - 3'd1;
						nx_coils = 1'b1;
						nx_done = d1;
						if (rampon_q && goal_q != 31'd0) begin
							if (c1 || c2) begin
								nx_need = 1'b1;
								nx_mop = c1 ? d1[15:0] : rem[15:0];
							end else begin
								nx_now = fast_q;
							end
						end
						if (goal_q != 31'd0 && d1 >= goal_q) begin
							nx_active = 1'b0;
							nx_coils = 1'b0;
							nx_fin = 1'b1;
							nx_succ = 1'b1;
						end
					end else begin
						nx_tick = t1[15:0];
					end
				end
			end
			shr_pkg::OP_MOVE: begin
				if (raw != 32'd0) begin
					if (active_q) begin
						nx_fin = 1'b1;
						nx_coils = 1'b0;
					end
					nx_fwd = ((!raw[31]) == defcw_q) ^ inv_q;
					nx_goal = mag[30:0];
					nx_done = '0;
					nx_rampon = ramp_q != 16'd0;
					nx_now = cruise_q;
					nx_active = 1'b1;
					nx_tick = '0;
					nx_sub = '0;
					nx_ems = '0;
				end
			end
			shr_pkg::OP_CONT: begin
				if (active_q) begin
					nx_fin = 1'b1;
					nx_coils = 1'b0;
				end
				nx_fwd = item_q.cont_dir_cw ^ inv_q;
				nx_goal = '0;
				nx_done = '0;
				nx_rampon = 1'b0;
				nx_now = fast_q;
				nx_active = 1'b1;
				nx_tick = '0;
				nx_sub = '0;
				nx_ems = '0;
			end
			shr_pkg::OP_SOFT: begin
				if (active_q) begin
					if (goal_q == 31'd0 || ng <= {1'b0, done_q}) begin
						nx_active = 1'b0;
						nx_coils = 1'b0;
						nx_goal = '0;
						nx_done = '0;
						nx_tick = '0;
						nx_fin = 1'b1;
					end else begin
						nx_goal = ng[30:0];
					end
				end
			end
			shr_pkg::OP_ESTOP: begin
				if (active_q) begin
					nx_active = 1'b0;
					nx_coils = 1'b0;
					nx_goal = '0;
					nx_done = '0;
					nx_tick = '0;
					nx_fin = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 16'd500;
			maxsp_q <= 13'd5000;
			ramp_q <= 16'd100;
			defcw_q <= 1'b1;
			inv_q <= 1'b0;
			tmo_q <= 24'd60000;
			dirty_q <= 1'b0;
			active_q <= 1'b0;
			coils_q <= 1'b0;
			fwd_q <= 1'b1;
			rampon_q <= 1'b0;
			phase_q <= 3'd0;
			goal_q <= '0;
			done_q <= '0;
			now_q <= 16'd2000;
			cruise_q <= 16'd2000;
			fast_q <= 16'd200;
			tick_q <= '0;
			subms_q <= '0;
			ems_q <= '0;
			need_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					shr_pkg::CFG_SPEED: begin
						speed_q <= cfg_data[15:0];
						dirty_q <= 1'b1;
					end
					shr_pkg::CFG_MAX_SPEED: begin
						maxsp_q <= cfg_data[12:0];
						dirty_q <= 1'b1;
					end
					shr_pkg::CFG_RAMP: ramp_q <= cfg_data[15:0];
					shr_pkg::CFG_DEF_CW: defcw_q <= cfg_data[0];
					shr_pkg::CFG_INVERT: inv_q <= cfg_data[0];
					shr_pkg::CFG_TIMEOUT: tmo_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.div_take) begin
				case (cmd.div_kind)
					shr_pkg::DK_CRUISE: cruise_q <= q_clamp;
					shr_pkg::DK_FAST: begin
						fast_q <= q_clamp;
						if (cruise_q < q_clamp) cruise_q <= q_clamp;
						dirty_q <= 1'b0;
					end
					default: now_q <= cruise_q - quo[15:0];
				endcase
			end
			if (cmd.exec) begin
				active_q <= nx_active;
				coils_q <= nx_coils;
				fwd_q <= nx_fwd;
				rampon_q <= nx_rampon;
				phase_q <= nx_phase;
				goal_q <= nx_goal;
				done_q <= nx_done;
				now_q <= nx_now;
				tick_q <= nx_tick;
				subms_q <= nx_sub;
				ems_q <= nx_ems;
				need_q <= nx_need;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_data;
		if (cmd.exec) begin
			stepped_q <= nx_stepped;
			fin_q <= nx_fin;
			succ_q <= nx_succ;
			mop_q <= nx_mop;
		end
		if (cmd.mul) prod_q <= mop_q * span;
		if (cmd.out_load) begin
			out_q.coil_pattern <= coils_q ? shr_pkg::half_step(phase_q) : 4'd0;
			out_q.stepped <= stepped_q;
			out_q.running <= active_q;
			out_q.steps_done <= done_q;
			out_q.steps_goal <= goal_q;
			out_q.finished <= fin_q;
			out_q.success <= succ_q;
		end
	end

	assign sts.dirty = dirty_q;
	assign sts.need_div = need_q;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

`default_nettype wire

FILE: rtl/shr_ctrl.sv
// ----------------------------------------------------------------------------
// shr_ctrl
// sequencer: interval recompute, execution, ramp multiply and divide, output
// ----------------------------------------------------------------------------
`default_nettype none

module shr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire shr_pkg::sts_t sts,
	output logic               in_ready,
	output shr_pkg::cmd_t      cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DIVC  = 4'd1;
	localparam logic [3:0] S_WAITC = 4'd2;
	localparam logic [3:0] S_DIVF  = 4'd3;
	localparam logic [3:0] S_WAITF = 4'd4;
	localparam logic [3:0] S_EXEC  = 4'd5;
	localparam logic [3:0] S_MUL   = 4'd6;
	localparam logic [3:0] S_DIVR  = 4'd7;
	localparam logic [3:0] S_WAITR = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	logic [3:0] state_q, state_nx;

	always_comb begin
		cmd = '0;
		cmd.div_kind = shr_pkg::DK_RAMP;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = sts.dirty ? S_DIVC : S_EXEC;
				end
			end
			S_DIVC: begin
				cmd.div_kind = shr_pkg::DK_CRUISE;
				cmd.div_start = 1'b1;
				state_nx = S_WAITC;
			end
			S_WAITC: begin
				cmd.div_kind = shr_pkg::DK_CRUISE;
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					state_nx = S_DIVF;
				end
			end
			S_DIVF: begin
				cmd.div_kind = shr_pkg::DK_FAST;
				cmd.div_start = 1'b1;
				state_nx = S_WAITF;
			end
			S_WAITF: begin
				cmd.div_kind = shr_pkg::DK_FAST;
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_nx = S_MUL;
			end
			S_MUL: begin
				if (sts.need_div) begin
					cmd.mul = 1'b1;
					state_nx = S_DIVR;
				end else begin
					state_nx = S_OUT;
				end
			end
			S_DIVR: begin
				cmd.div_start = 1'b1;
				state_nx = S_WAITR;
			end
			S_WAITR: begin
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					state_nx = S_OUT;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign in_ready = state_q == S_IDLE;

endmodule

`default_nettype wire

FILE: rtl/stepper_half_step_ramp_controller_top.sv
// ----------------------------------------------------------------------------
// stepper_half_step_ramp_controller_top
// half-step unipolar stepper driver with trapezoidal ramp and move timeout
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready/in_data) takes one request per item: a
//   one-microsecond tick, a counted move, a continuous move, a soft stop or
//   an emergency stop. every request gives exactly one result on the out
//   channel (out_valid/out_ready/out_data) with coil drive and move status.
//   cfg_we/cfg_index/cfg_data write a register; user keeps to idle, unchecked.
// timing:
//   a taken request is loaded, executed and its result put in the output
//   register; a step inside a ramp adds the ramp multiply and a serial
//   divide; the first request after a speed register write adds the two
//   interval divides, cruise then fast, before it executes. the shared
//   serial divider does all these divides. one request is in work at a time.
//   the next request is taken while a result still waits in the output
//   register; a stalled receiver holds the result and blocks only the
//   finish of the following request.
// reset:
//   arst_n clears the motion state, releases the coils and loads the
//   default registers (500 pps cruise, 5000 pps max, 100 ramp steps).
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_half_step_ramp_controller_top #(
	parameter int TICKS_PER_MS = shr_pkg::DEF_TICKS_PER_MS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire shr_pkg::in_t in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output shr_pkg::out_t     out_data,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [23:0]  cfg_data
);

	// commands from the sequencer, status back from the datapath
	shr_pkg::cmd_t cmd;
	shr_pkg::sts_t sts;

	// sequencer owns the request handshake
	shr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.sts(sts),
		.in_ready(in_ready),
		.cmd(cmd)
	);

	// datapath holds registers, motion state, divider and output register
	shr_dp #(
		.TICKS_PER_MS(TICKS_PER_MS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.out_ready(out_ready),
		.cmd(cmd),
		.sts(sts),
		.out_valid(out_valid),
		.out_data(out_data)
	);

endmodule

`default_nettype wire

FILE: rtl/shr_chk.sv
// ----------------------------------------------------------------------------
// shr_chk
// port checker for the stepper ramp controller, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "stepper_half_step_ramp_controller_top_macros.svh"

module shr_chk (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire shr_pkg::out_t out_data
);

	// a stalled result holds
	`SHR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "out held")

	// success only comes with a finish
	`SHR_ASSERT_IMP(a_succ_fin, out_valid && out_data.success, out_data.finished && !out_data.running, "success")

	// released coils whenever no move runs
	`SHR_ASSERT_IMP(a_coil_idle, out_valid && !out_data.running, out_data.coil_pattern == 4'd0, "coils")

	// a step without a finish leaves the move running
	`SHR_ASSERT_IMP(a_step_run, out_valid && out_data.stepped && !out_data.finished, out_data.running, "step")

endmodule

bind stepper_half_step_ramp_controller_top shr_chk u_shr_chk (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);

`default_nettype wire
